>>> src/pdm_pkg.sv
package pdm_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned SUM_W        = 36;
  localparam int unsigned CNT_W        = 4;
  localparam int unsigned IDX_W        = 3;
  localparam int unsigned MAX_CHANNELS = 8;

  // divider: 40-bit dividend, 8 quotient bits per cycle
  localparam int unsigned DIV_DIGIT_W  = 8;
  localparam int unsigned DIV_W        = 40;
  localparam int unsigned DIV_STEPS    = DIV_W / DIV_DIGIT_W;
  localparam int unsigned STEP_W       = 3;
  localparam int unsigned REM_W        = CNT_W - 1;

  // frame queue
  localparam int unsigned Q_DEPTH      = 2;
  localparam int unsigned Q_PTR_W      = 1;
  localparam int unsigned Q_CNT_W      = 2;

  localparam int unsigned APB_ADDR_W   = 3;
  localparam int unsigned APB_DATA_W   = 32;

  typedef enum logic [1:0] {
    FMT_8  = 2'd0,
    FMT_16 = 2'd1,
    FMT_24 = 2'd2,
    FMT_32 = 2'd3
  } fmt_e;

  typedef enum logic [0:0] {
    REG_SAMPLE_FORMAT = 1'b0,
    REG_CHANNEL_COUNT = 1'b1
  } reg_idx_e;

  localparam fmt_e             FORMAT_RESET = FMT_16;
  localparam logic [CNT_W-1:0] COUNT_RESET  = 4'd2;

  typedef struct packed {
    fmt_e             fmt;
    logic [CNT_W-1:0] count_raw;
    logic [CNT_W-1:0] count_eff;  // 1..MAX_CHANNELS
  } cfg_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        chan_cnt;
    fmt_e                    fmt;
    logic                    buf_end;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // sign-extend the raw word; 24-bit samples land in the top of a 32-bit word
  function automatic logic signed [SUM_W-1:0] decode_sample(fmt_e fmt,
                                                            logic [WORD_W-1:0] w);
    logic signed [SUM_W-1:0] s;
    case (fmt)
      FMT_8:   s = {{(SUM_W-8){w[7]}}, w[7:0]};
      FMT_16:  s = {{(SUM_W-16){w[15]}}, w[15:0]};
      FMT_24:  s = {{(SUM_W-32){w[23]}}, w[23:0], 8'h00};
      FMT_32:  s = {{(SUM_W-32){w[31]}}, w};
      default: s = {{(SUM_W-32){w[31]}}, w};
    endcase
    return s;
  endfunction

endpackage

>>> src/pdm_if.sv
interface pdm_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_word;
  logic        last_in_buffer;

  modport source (output valid, output sample_word, output last_in_buffer, input ready);
  modport sink   (input valid, input sample_word, input last_in_buffer, output ready);
endinterface

interface pdm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] mono_sample;
  logic        buffer_end;

  modport source (output valid, output mono_sample, output buffer_end, input ready);
  modport sink   (input valid, input mono_sample, input buffer_end, output ready);
endinterface

>>> src/pdm_regs.sv
module pdm_regs import pdm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  fmt_e             fmt_q;
  logic [CNT_W-1:0] count_q;
  reg_idx_e         idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= FORMAT_RESET;
      count_q <= COUNT_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_SAMPLE_FORMAT: fmt_q   <= fmt_e'(pwdata[1:0]);
        REG_CHANNEL_COUNT: count_q <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SAMPLE_FORMAT: prdata = {{(APB_DATA_W-2){1'b0}}, fmt_q};
      REG_CHANNEL_COUNT: prdata = {{(APB_DATA_W-CNT_W){1'b0}}, count_q};
      default:           prdata = '0;
    endcase
  end

  // zero counts as one channel, large counts saturate
  always_comb begin
    cfg_o.fmt       = fmt_q;
    cfg_o.count_raw = count_q;
    if (count_q == '0)
      cfg_o.count_eff = CNT_W'(1);
    else if (count_q > CNT_W'(MAX_CHANNELS))
      cfg_o.count_eff = CNT_W'(MAX_CHANNELS);
    else
      cfg_o.count_eff = count_q;
  end

endmodule

>>> src/pdm_front.sv
module pdm_front import pdm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  pdm_in_if.sink   in_i,
  input  cfg_t     cfg_i,
  input  q_stat_t  q_stat_i,
  output logic     push_o,
  output q_entry_t entry_o
);

  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [IDX_W-1:0]        idx_q;
  logic                    accept;
  logic                    frame_done;

  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid & in_i.ready;
  assign sum_d      = sum_q + decode_sample(cfg_i.fmt, in_i.sample_word);
  assign frame_done = ({1'b0, idx_q} + CNT_W'(1)) >= cfg_i.count_eff;
  assign push_o     = accept & frame_done;

  always_comb begin
    entry_o.sum      = sum_d;
    entry_o.chan_cnt = cfg_i.count_eff;
    entry_o.fmt      = cfg_i.fmt;
    entry_o.buf_end  = in_i.last_in_buffer;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      idx_q <= '0;
    end else if (accept) begin
      if (frame_done) begin
        sum_q <= '0;
        idx_q <= '0;
      end else begin
        sum_q <= sum_d;
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

endmodule

>>> src/pdm_queue.sv
module pdm_queue import pdm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  input  logic     pop_i,
  output q_entry_t entry_o,
  output q_stat_t  stat_o
);

  q_entry_t             mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0]   cnt_q;

  assign entry_o      = mem_q[rd_ptr_q];
  assign stat_o.full  = cnt_q == Q_CNT_W'(Q_DEPTH);
  assign stat_o.empty = cnt_q == '0;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + Q_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - Q_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> src/pdm_back.sv
module pdm_back import pdm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  q_stat_t  q_stat_i,
  input  q_entry_t entry_i,
  output logic     pop_o,
  pdm_out_if.source out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } state_e;

  state_e               state_q, state_d;
  logic [DIV_W-1:0]     div_q, div_d;      // dividend in, quotient out
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 neg_q, neg_d;
  fmt_e                 fmt_q, fmt_d;
  logic                 last_q, last_d;
  logic                 out_valid_q, out_valid_d;
  logic [WORD_W-1:0]    mono_q, mono_d;
  logic                 end_q, end_d;
  logic                 out_free;
  logic                 pop;

  // one radix-256 digit: eight restoring steps on a narrow remainder
  logic [CNT_W-1:0]       trial;
  logic [REM_W-1:0]       rem_n;
  logic [DIV_DIGIT_W-1:0] qdig;
  logic [SUM_W-1:0]       mag;
  logic [WORD_W-1:0]      res;

  always_comb begin
    rem_n = rem_q;
    qdig  = '0;
    trial = '0;
    for (int i = DIV_DIGIT_W - 1; i >= 0; i--) begin
      trial = {rem_n, div_q[DIV_W-DIV_DIGIT_W+i]};
      if (trial >= cnt_q) begin
        trial   = trial - cnt_q;
        qdig[i] = 1'b1;
      end
      rem_n = trial[REM_W-1:0];
    end
  end

  assign mag      = entry_i.sum[SUM_W-1] ? SUM_W'(-entry_i.sum) : SUM_W'(entry_i.sum);
  assign res      = neg_q ? (~div_q[WORD_W-1:0] + WORD_W'(1)) : div_q[WORD_W-1:0];
  assign out_free = !out_valid_q || out_o.ready;
  assign pop_o    = pop;

  always_comb begin
    state_d     = state_q;
    div_d       = div_q;
    rem_d       = rem_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    fmt_d       = fmt_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    mono_d      = mono_q;
    end_d       = end_q;
    pop         = 1'b0;

    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        pop = !q_stat_i.empty;
      end
      S_DIV: begin
        div_d  = {div_q[DIV_W-DIV_DIGIT_W-1:0], qdig};
        rem_d  = rem_n;
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_STEPS - 1)) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          end_d       = last_q;
          case (fmt_q)
            FMT_8:   mono_d = {24'h0, res[7:0]};
            FMT_16:  mono_d = {16'h0, res[15:0]};
            FMT_24:  mono_d = {8'h0, res[31:8]};
            FMT_32:  mono_d = res;
            default: mono_d = res;
          endcase
          state_d = S_IDLE;
          pop     = !q_stat_i.empty;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (pop) begin
      div_d   = {{(DIV_W-SUM_W){1'b0}}, mag};
      rem_d   = '0;
      step_d  = '0;
      cnt_d   = entry_i.chan_cnt;
      neg_d   = entry_i.sum[SUM_W-1];
      fmt_d   = entry_i.fmt;
      last_d  = entry_i.buf_end;
      state_d = S_DIV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      div_q       <= div_d;
      rem_q       <= rem_d;
      cnt_q       <= cnt_d;
      neg_q       <= neg_d;
      fmt_q       <= fmt_d;
      last_q      <= last_d;
      mono_q      <= mono_d;
      end_q       <= end_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.mono_sample = mono_q;
  assign out_o.buffer_end  = end_q;

endmodule

>>> src/pcm_downmix_to_mono.sv
// channel  dir  transfer                     payload
// in_i     in   one interleaved channel      sample_word[31:0], last_in_buffer
// out_o    out  one averaged mono sample     mono_sample[31:0], buffer_end
// apb      in   register write / read        sample_format @0x0, channel_count @0x4
//
// Channel samples enter one per cycle into the accumulator while the frame queue has room.
// Each completed frame goes through the back end's radix-256 divider (40-bit dividend,
// 8 quotient bits a cycle), then is sign-fixed and loaded into the output register.
// rst_ni is async, active low; it clears the accumulator, the queue and the output valid.
// A stalled output holds the back end; the 2-entry queue keeps the front taking samples.
module pcm_downmix_to_mono import pdm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pdm_in_if.sink                in_i,
  pdm_out_if.source             out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t     cfg;
  q_stat_t  q_stat;
  q_entry_t push_entry;
  q_entry_t head_entry;
  logic     q_push;
  logic     q_pop;

  // config registers; count is clamped to 1..MAX_CHANNELS here
  pdm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // front: decode each sample, accumulate, push a frame sum when the frame closes
  pdm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg),
    .q_stat_i (q_stat),
    .push_o   (q_push),
    .entry_o  (push_entry)
  );

  // frame queue: sum, count, format and end flag travel together
  pdm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .pop_i   (q_pop),
    .entry_o (head_entry),
    .stat_o  (q_stat)
  );

  // back: divide magnitude by count (truncates toward zero), restore sign, format
  pdm_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .entry_i  (head_entry),
    .pop_o    (q_pop),
    .out_o    (out_o)
  );

`ifndef NO_ASSERTIONS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("frame pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("frame popped from an empty queue");

  a_push_needs_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (in_i.valid && in_i.ready))
    else $error("frame pushed without a sample transfer");
`endif

endmodule

>>> bench/pcm_downmix_to_mono_test.sv
module pcm_downmix_to_mono_test import pdm_pkg::*;;

  // Roughly this many random channel samples after the directed part.
  localparam int unsigned ITEMS = 1850;
  // Cycles to wait once nothing is expected any more.
  localparam int unsigned SETTLE_CYCLES = 24;
  // Hard stop, in time units (clock period is 2).
  localparam int unsigned RUN_LIMIT = 1_000_000;

  // Idle percentages per phase: sender-heavy stalls on the sink first, then
  // the other way round, then full throughput.
  localparam int unsigned SRC_IDLE [3] = '{13, 80, 0};
  localparam int unsigned SNK_IDLE [3] = '{80, 13, 0};

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } chan_sample_t;

  typedef struct packed {
    logic [WORD_W-1:0] sample;
    logic              buf_end;
  } mono_sample_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  pdm_in_if  in_ch ();
  pdm_out_if out_ch ();

  pcm_downmix_to_mono u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Channel samples waiting to be driven, and mono samples waiting to come out.
  chan_sample_t pending_samples [$];
  mono_sample_t expected_mono [$];
  chan_sample_t drive_sample;
  mono_sample_t head_mono;

  // Mirror of the block: register copies plus the frame accumulator.
  fmt_e                    cur_fmt;
  logic [CNT_W-1:0]        cur_count;
  logic signed [SUM_W-1:0] frame_sum;
  logic [IDX_W-1:0]        frame_idx;

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned fail_cnt;

  // Raw word -> signed value in the accumulator domain. 24-bit samples come from
  // the low three bytes and are scaled by 256, to sit in the top of a 32-bit word.
  function automatic logic signed [SUM_W-1:0] widen_sample(fmt_e f, logic [WORD_W-1:0] w);
    logic signed [7:0]       s8;
    logic signed [15:0]      s16;
    logic signed [23:0]      s24;
    logic signed [SUM_W-1:0] r;
    s8  = w[7:0];
    s16 = w[15:0];
    s24 = w[23:0];
    case (f)
      FMT_8: begin
        r = SUM_W'(s8);
      end
      FMT_16: begin
        r = SUM_W'(s16);
      end
      FMT_24: begin
        r = SUM_W'(s24);
        r = r <<< 8;
      end
      default: begin
        r = SUM_W'($signed(w));
      end
    endcase
    return r;
  endfunction

  // Zero means one channel, anything past the maximum saturates.
  function automatic int unsigned eff_channels(logic [CNT_W-1:0] c);
    if (c == 0) return 1;
    if (c > MAX_CHANNELS) return MAX_CHANNELS;
    return 32'(c);
  endfunction

  // Average back into the sample format; upper bits stay zero.
  function automatic logic [WORD_W-1:0] pack_average(fmt_e f, logic signed [SUM_W-1:0] avg);
    logic [WORD_W-1:0] a;
    a = avg[WORD_W-1:0];
    case (f)
      FMT_8:   return {24'd0, a[7:0]};
      FMT_16:  return {16'd0, a[15:0]};
      FMT_24:  return {8'd0, a[31:8]};
      default: return a;
    endcase
  endfunction

  // Accumulate one accepted channel sample; a completed frame yields one
  // mono sample, divided with truncation toward zero.
  function automatic void mix_channel_sample(logic [WORD_W-1:0] w, logic last);
    int unsigned             n;
    logic signed [SUM_W-1:0] divisor;
    mono_sample_t            m;
    n         = eff_channels(cur_count);
    frame_sum = frame_sum + widen_sample(cur_fmt, w);
    if (frame_idx + 1 < n) begin
      frame_idx = frame_idx + 1'b1;
    end else begin
      divisor   = SUM_W'(n);
      m.sample  = pack_average(cur_fmt, frame_sum / divisor);
      m.buf_end = last;
      expected_mono.push_back(m);
      frame_sum = '0;
      frame_idx = '0;
    end
  endfunction

  // Mostly full-range random words; now and then the format's extremes, zero
  // or minus one, always with junk in the unused upper bits.
  function automatic logic [WORD_W-1:0] random_word(fmt_e f);
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] pat;
    logic [WORD_W-1:0] junk;
    case (f)
      FMT_8:   mask = 32'h0000_00FF;
      FMT_16:  mask = 32'h0000_FFFF;
      FMT_24:  mask = 32'h00FF_FFFF;
      default: mask = '1;
    endcase
    junk = $urandom;
    case ($urandom_range(9))
      0:       pat = mask >> 1;
      1:       pat = (mask >> 1) + 1'b1;
      2:       pat = '0;
      3:       pat = mask;
      default: pat = junk;
    endcase
    return (junk & ~mask) | (pat & mask);
  endfunction

  function automatic void queue_sample(logic [WORD_W-1:0] w, logic last);
    chan_sample_t s;
    s.word = w;
    s.last = last;
    pending_samples.push_back(s);
  endfunction

  // APB write: setup, then access; the register takes the value at the edge
  // where psel/penable/pwrite/pready are all high. Mirror follows right after.
  task automatic write_reg(reg_idx_e r, logic [APB_DATA_W-1:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (r == REG_SAMPLE_FORMAT) cur_fmt = fmt_e'(v[1:0]);
    else cur_count = v[CNT_W-1:0];
  endtask

  // Hold off until every queued sample is taken and every mono sample is
  // back, then give a partial frame time to settle. Checked on the falling
  // edge so all updates of the rising edge are visible.
  task automatic settle();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || in_ch.valid || expected_mono.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #(RUN_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Sender: a new transfer is offered only when the slot is free or the
  // current one is taken this edge; valid gets at most one update per edge.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        drive_sample          = pending_samples.pop_front();
        in_ch.valid          <= 1'b1;
        in_ch.sample_word    <= drive_sample.word;
        in_ch.last_in_buffer <= drive_sample.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Every accepted channel sample goes through the predictor at once, with
  // the format and count in force at that moment.
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      mix_channel_sample(in_ch.sample_word, in_ch.last_in_buffer);
    end
  end

  // Receiver back-pressure.
  always @(posedge clk_i) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Mono sample checker: in-order against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_mono.size() == 0) begin
        $error("unexpected mono transfer: mono_sample %h buffer_end %b",
               out_ch.mono_sample, out_ch.buffer_end);
        fail_cnt++;
      end else begin
        head_mono = expected_mono.pop_front();
        if (out_ch.mono_sample !== head_mono.sample) begin
          $error("mono_sample: expected %h, got %h", head_mono.sample, out_ch.mono_sample);
          fail_cnt++;
        end
        if (out_ch.buffer_end !== head_mono.buf_end) begin
          $error("buffer_end: expected %b, got %b", head_mono.buf_end, out_ch.buffer_end);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    int unsigned       total;
    int unsigned       seg;
    int unsigned       n;
    int unsigned       ph;
    fmt_e              f;
    logic [CNT_W-1:0]  c;
    logic [WORD_W-1:0] v;

    rst_ni               = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.sample_word    = '0;
    in_ch.last_in_buffer = 1'b0;
    out_ch.ready         = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    cur_fmt              = FORMAT_RESET;
    cur_count            = COUNT_RESET;
    frame_sum            = '0;
    frame_idx            = '0;
    fail_cnt             = 0;
    src_idle_pct         = SRC_IDLE[0];
    snk_idle_pct         = SNK_IDLE[0];

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset config, 16-bit stereo. Flag on the first channel is ignored;
    // full-scale positive and negative; -1 + 0 truncates to zero.
    queue_sample(32'h0000_7FFF, 1'b1);
    queue_sample(32'hFFFF_7FFF, 1'b0);
    queue_sample(32'h0000_8000, 1'b0);
    queue_sample(32'h1234_8000, 1'b0);
    queue_sample(32'h0000_FFFF, 1'b0);
    queue_sample(32'h0000_0000, 1'b1);
    settle();

    // 8-bit, count written as zero -> one channel; junk in the upper bits.
    write_reg(REG_SAMPLE_FORMAT, 32'hFFFF_FFFC | FMT_8);
    write_reg(REG_CHANNEL_COUNT, 32'hFFFF_FFF0);
    queue_sample(32'h0000_007F, 1'b0);
    queue_sample(32'hFFFF_FF80, 1'b0);
    queue_sample(32'hABCD_EF01, 1'b1);
    settle();

    // 24-bit packed, count 15 saturates to eight channels.
    write_reg(REG_SAMPLE_FORMAT, FMT_24);
    write_reg(REG_CHANNEL_COUNT, 32'h0000_000F);
    repeat (4) queue_sample(32'hAA7F_FFFF, 1'b0);
    repeat (3) queue_sample(32'h0080_0000, 1'b0);
    queue_sample(32'h00FF_FFFF, 1'b1);
    settle();

    // 32-bit, three channels: most negative sum, then a mixed frame.
    write_reg(REG_SAMPLE_FORMAT, FMT_32);
    write_reg(REG_CHANNEL_COUNT, 32'd3);
    repeat (3) queue_sample(32'h8000_0000, 1'b0);
    queue_sample(32'h7FFF_FFFF, 1'b0);
    queue_sample(32'h7FFF_FFFF, 1'b0);
    queue_sample(32'hFFFF_FFFF, 1'b1);
    settle();

    // Random segments. Each starts from a drained block with a new setting;
    // odd segment lengths leave partial frames across config changes.
    total = 0;
    seg   = 0;
    while (total < ITEMS) begin
      ph           = total * 3 / ITEMS;
      src_idle_pct = SRC_IDLE[ph];
      snk_idle_pct = SNK_IDLE[ph];
      case (seg)
        0: begin
          f = FMT_8;
          c = 4'd1;
        end
        1: begin
          f = FMT_32;
          c = 4'd8;
        end
        2: begin
          f = FMT_24;
          c = 4'd15;
        end
        default: begin
          f = fmt_e'($urandom_range(3));
          c = ($urandom_range(3) == 0) ? CNT_W'($urandom_range(15))
                                       : CNT_W'($urandom_range(1, MAX_CHANNELS));
        end
      endcase
      settle();
      v      = $urandom;
      v[1:0] = f;
      write_reg(REG_SAMPLE_FORMAT, v);
      v              = $urandom;
      v[CNT_W-1:0]   = c;
      write_reg(REG_CHANNEL_COUNT, v);
      n = $urandom_range(40, 160);
      repeat (n) queue_sample(random_word(cur_fmt), ($urandom_range(7) == 0));
      total += n;
      seg++;
    end

    settle();
    if (fail_cnt == 0 && expected_mono.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
src/pdm_pkg.sv
src/pdm_if.sv
src/pdm_regs.sv
src/pdm_front.sv
src/pdm_queue.sv
src/pdm_back.sv
src/pcm_downmix_to_mono.sv
bench/pcm_downmix_to_mono_test.sv
